FILE: sv/cbss_pkg.sv
// shared constants, types and arithmetic helpers for the band-split saturator
package cbss_pkg;

	localparam int MAX_STAGES = 16;
	localparam int BANDS = 12;
	localparam int ENTRIES = MAX_STAGES * BANDS;
	localparam int ADDR_W = $clog2(ENTRIES);
	localparam int STG_W = $clog2(MAX_STAGES + 1);
	localparam int BND_W = $clog2(BANDS);
	localparam int CFG_W = 48;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_GAINS_A = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAINS_B = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAINS_C = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAINS_D = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRIVE_PAD = 3'd4;
	localparam logic [IDX_W-1:0] REG_STAGES = 3'd5;
	localparam logic [IDX_W-1:0] REG_COEF = 3'd6;

	localparam logic signed [31:0] CLIP_PF = 32'sd545624712;
	localparam logic signed [31:0] ONE_PF = 32'sd268435456;
	localparam logic [15:0] GAIN_ONE = 16'd16384;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic [ADDR_W-1:0] addr;
		logic [31:0] wr_level;
		logic [31:0] wr_slope;
	} mem_req_t;

	// round half up, then arithmetic shift
	function automatic logic signed [65:0] rsh(input logic signed [65:0] v,
			input logic [5:0] s);
		logic signed [65:0] half;
		half = 66'sd1 <<< (s - 6'd1);
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		else if (v < -66'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic logic signed [31:0] msat(input logic signed [65:0] p,
			input logic [5:0] s);
		return sat32(rsh(p, s));
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(66'(a) - 66'(b));
	endfunction

	function automatic logic signed [31:0] clip(input logic signed [31:0] v);
		if (v > CLIP_PF) return CLIP_PF;
		else if (v < -CLIP_PF) return -CLIP_PF;
		else return v;
	endfunction

endpackage

FILE: sv/cbss_state_mem.sv
// band level and slope storage with per-entry valid bits
module cbss_state_mem (
	input  logic clk,
	input  logic arst_n,
	input  cbss_pkg::mem_req_t req,
	output logic [31:0] rd_level,
	output logic [31:0] rd_slope
);

	logic [31:0] lvl_mem [cbss_pkg::ENTRIES];
	logic [31:0] slp_mem [cbss_pkg::ENTRIES];
	logic [cbss_pkg::ENTRIES-1:0] vld_q;
	logic rd_vld_q;
	logic [31:0] lvl_rd_q;
	logic [31:0] slp_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			lvl_mem[req.addr] <= req.wr_level;
			slp_mem[req.addr] <= req.wr_slope;
		end
		if (req.rd_en) begin
			lvl_rd_q <= lvl_mem[req.addr];
			slp_rd_q <= slp_mem[req.addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) vld_q[req.addr] <= 1'b1;
			if (req.rd_en) rd_vld_q <= vld_q[req.addr];
		end
	end

	assign rd_level = rd_vld_q ? lvl_rd_q : 32'd0;
	assign rd_slope = rd_vld_q ? slp_rd_q : 32'd0;

endmodule

FILE: sv/cascaded_band_split_saturator.sv
// cascaded band-split saturator top level
// sequence per item: n stages of twelve band updates and one shaping each, then the drive pad
// (skipped when its gain is unity or more) and a final shaping before out_valid
// one item at a time: the next item is taken the cycle after the result registers
// all multiplies share one registered 33x33 multiplier, state read and written in one memory
// reset: config registers to defaults, band state reads as zero via valid bits, no clear pass
module cascaded_band_split_saturator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [23:0] in_sample,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [23:0] out_sample,
	input  logic cfg_wr_en,
	input  logic [cbss_pkg::IDX_W-1:0] cfg_index,
	input  logic [cbss_pkg::CFG_W-1:0] cfg_data
);

	typedef enum logic [25:0] {
		S_IDLE = 26'd1 << 0,
		S_INIT = 26'd1 << 1,
		S_RD   = 26'd1 << 2,
		S_B1   = 26'd1 << 3,
		S_B2   = 26'd1 << 4,
		S_B3   = 26'd1 << 5,
		S_B4   = 26'd1 << 6,
		S_B5   = 26'd1 << 7,
		S_B6   = 26'd1 << 8,
		S_B7   = 26'd1 << 9,
		S_B8   = 26'd1 << 10,
		S_B9   = 26'd1 << 11,
		S_B10  = 26'd1 << 12,
		S_B11  = 26'd1 << 13,
		S_SE0  = 26'd1 << 14,
		S_SE1  = 26'd1 << 15,
		S_SE2  = 26'd1 << 16,
		S_PAD0 = 26'd1 << 17,
		S_PAD1 = 26'd1 << 18,
		S_SH1  = 26'd1 << 19,
		S_SH2  = 26'd1 << 20,
		S_SHM  = 26'd1 << 21,
		S_SHA  = 26'd1 << 22,
		S_SHV  = 26'd1 << 23,
		S_SHO  = 26'd1 << 24,
		S_OUT  = 26'd1 << 25
	} state_t;

	state_t state_q;

	logic [47:0] gains_a_q, gains_b_q, gains_c_q;
	logic [31:0] gains_d_q, drive_pad_q, coef_q;
	logic [4:0] stages_q;

	logic [cbss_pkg::STG_W-1:0] stg_q;
	logic [cbss_pkg::BND_W-1:0] bnd_q;
	logic [cbss_pkg::ADDR_W-1:0] addr_q;
	logic [1:0] k_q;
	logic fin_q;

	logic signed [31:0] sig_q, band_q, acc_q, lvl_q, slp_q, diff_q, t_q, tg_q, bf_q, nb_q;
	logic signed [31:0] v_q, x_q, h_q;
	logic [15:0] f_q, fn_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [23:0] out_q;
	logic out_valid_q;

	cbss_pkg::mem_req_t mem_req;
	logic [31:0] rd_level, rd_slope;

	logic signed [16:0] fs, gc;
	logic [15:0] gain;
	logic [4:0] n_stages;
	logic signed [31:0] x_new, shp, o_wide;
	logic [17:0] fn_raw;

	cbss_state_mem u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.req(mem_req),
		.rd_level(rd_level),
		.rd_slope(rd_slope)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_a_q <= 48'h400040004000;
			gains_b_q <= 48'h400040004000;
			gains_c_q <= 48'h400040004000;
			gains_d_q <= 32'h40004000;
			drive_pad_q <= 32'h40004000;
			stages_q <= 5'd11;
			coef_q <= 32'h4FDF6D95;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cbss_pkg::REG_GAINS_A: gains_a_q <= cfg_data;
				cbss_pkg::REG_GAINS_B: gains_b_q <= cfg_data;
				cbss_pkg::REG_GAINS_C: gains_c_q <= cfg_data;
				cbss_pkg::REG_GAINS_D: gains_d_q <= cfg_data[31:0];
				cbss_pkg::REG_DRIVE_PAD: drive_pad_q <= cfg_data[31:0];
				cbss_pkg::REG_STAGES: stages_q <= cfg_data[4:0];
				cbss_pkg::REG_COEF: coef_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign n_stages = (stages_q > 5'(cbss_pkg::MAX_STAGES)) ? 5'(cbss_pkg::MAX_STAGES) : stages_q;
	assign fs = signed'({1'b0, f_q});
	assign gc = 17'sd32768 - fs;

	always_comb begin
		case (bnd_q)
			4'd0: gain = gains_a_q[15:0];
			4'd1: gain = gains_a_q[31:16];
			4'd2: gain = gains_a_q[47:32];
			4'd3: gain = gains_b_q[15:0];
			4'd4: gain = gains_b_q[31:16];
			4'd5: gain = gains_b_q[47:32];
			4'd6: gain = gains_c_q[15:0];
			4'd7: gain = gains_c_q[31:16];
			4'd8: gain = gains_c_q[47:32];
			4'd9: gain = gains_d_q[15:0];
			4'd10: gain = gains_d_q[31:16];
			default: gain = cbss_pkg::GAIN_ONE;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = 33'sd0;
		mul_b = 33'sd0;
		unique case (state_q)
			S_B1: begin
				mul_a = signed'({17'd0, f_q});
				mul_b = signed'({17'd0, coef_q[31:16]});
			end
			S_B2: begin
				mul_a = 33'(slp_q);
				mul_b = 33'(gc);
			end
			S_B3: begin
				mul_a = 33'(diff_q);
				mul_b = 33'(fs);
			end
			S_B4: begin
				mul_a = 33'(band_q);
				mul_b = 33'(fs);
			end
			S_B5: begin
				mul_a = 33'(slp_q);
				mul_b = 33'(fs);
			end
			S_B7: begin
				mul_a = 33'(t_q);
				mul_b = 33'(gc);
			end
			S_B9: begin
				mul_a = 33'(nb_q);
				mul_b = 33'(fs);
			end
			S_B10: begin
				mul_a = 33'(diff_q);
				mul_b = signed'({17'd0, gain});
			end
			S_SE1: begin
				mul_a = 33'(acc_q);
				mul_b = signed'({17'd0, drive_pad_q[15:0]});
			end
			S_PAD0: begin
				mul_a = 33'(sig_q);
				mul_b = signed'({17'd0, drive_pad_q[31:16]});
			end
			S_SH1: begin
				mul_a = 33'(v_q);
				mul_b = 33'(v_q);
			end
			S_SHM: begin
				mul_a = 33'(x_q);
				mul_b = 33'(h_q);
			end
			S_SHV: begin
				mul_a = 33'(v_q);
				mul_b = 33'(h_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign fn_raw = 18'((prod_q + 66'sd16384) >>> 15);
	assign x_new = cbss_pkg::msat(prod_q, 6'd28);
	assign shp = cbss_pkg::msat(prod_q, 6'd28);
	assign o_wide = cbss_pkg::msat(66'(shp), 6'd6);

	always_comb begin
		mem_req.rd_en = (state_q == S_RD);
		mem_req.wr_en = (state_q == S_B11);
		mem_req.addr = addr_q;
		mem_req.wr_level = lvl_q;
		mem_req.wr_slope = slp_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stg_q <= '0;
			bnd_q <= '0;
			addr_q <= '0;
			k_q <= '0;
			fin_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sig_q <= 32'(in_sample) <<< 6;
						stg_q <= '0;
						addr_q <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					acc_q <= '0;
					band_q <= sig_q;
					f_q <= coef_q[15:0];
					bnd_q <= '0;
					state_q <= (5'(stg_q) == n_stages) ? S_PAD0 : S_RD;
				end
				S_RD: state_q <= S_B1;
				S_B1: begin
					lvl_q <= rd_level;
					slp_q <= rd_slope;
					diff_q <= cbss_pkg::sub_sat(band_q, rd_level);
					state_q <= S_B2;
				end
				S_B2: begin
					fn_q <= (fn_raw > 18'd65535) ? 16'hFFFF : fn_raw[15:0];
					state_q <= S_B3;
				end
				S_B3: begin
					t_q <= cbss_pkg::msat(prod_q, 6'd15);
					state_q <= S_B4;
				end
				S_B4: begin
					slp_q <= cbss_pkg::add_sat(t_q, cbss_pkg::msat(prod_q, 6'd15));
					state_q <= S_B5;
				end
				S_B5: begin
					bf_q <= cbss_pkg::msat(prod_q, 6'd15);
					state_q <= S_B6;
				end
				S_B6: begin
					t_q <= cbss_pkg::add_sat(lvl_q, cbss_pkg::msat(prod_q, 6'd15));
					state_q <= S_B7;
				end
				S_B7: state_q <= S_B8;
				S_B8: begin
					tg_q <= cbss_pkg::msat(prod_q, 6'd15);
					nb_q <= cbss_pkg::add_sat(cbss_pkg::msat(prod_q, 6'd15), bf_q);
					state_q <= S_B9;
				end
				S_B9: begin
					diff_q <= cbss_pkg::sub_sat(band_q, nb_q);
					state_q <= S_B10;
				end
				S_B10: begin
					lvl_q <= cbss_pkg::add_sat(tg_q, cbss_pkg::msat(prod_q, 6'd15));
					state_q <= S_B11;
				end
				S_B11: begin
					acc_q <= cbss_pkg::add_sat(acc_q, cbss_pkg::msat(prod_q, 6'd14));
					band_q <= nb_q;
					f_q <= fn_q;
					addr_q <= addr_q + 1'b1;
					if (bnd_q == 4'(cbss_pkg::BANDS - 1)) begin
						state_q <= S_SE0;
					end else begin
						bnd_q <= bnd_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_SE0: begin
					acc_q <= cbss_pkg::add_sat(acc_q, band_q);
					state_q <= S_SE1;
				end
				S_SE1: state_q <= S_SE2;
				S_SE2: begin
					v_q <= cbss_pkg::clip(cbss_pkg::msat(prod_q, 6'd14));
					fin_q <= 1'b0;
					state_q <= S_SH1;
				end
				S_PAD0: begin
					fin_q <= 1'b1;
					if (drive_pad_q[31:16] < cbss_pkg::GAIN_ONE) begin
						state_q <= S_PAD1;
					end else begin
						v_q <= cbss_pkg::clip(sig_q);
						state_q <= S_SH1;
					end
				end
				S_PAD1: begin
					v_q <= cbss_pkg::clip(cbss_pkg::msat(prod_q, 6'd14));
					state_q <= S_SH1;
				end
				S_SH1: state_q <= S_SH2;
				S_SH2: begin
					x_q <= x_new;
					h_q <= cbss_pkg::sub_sat(cbss_pkg::ONE_PF,
						cbss_pkg::msat(66'(x_new), 6'd7));
					k_q <= '0;
					state_q <= S_SHM;
				end
				S_SHM: state_q <= S_SHA;
				S_SHA: begin
					// horner steps shift by 34, 33, 32, 31
					h_q <= cbss_pkg::sub_sat(cbss_pkg::ONE_PF,
						cbss_pkg::msat(prod_q, 6'd34 - 6'(k_q)));
					k_q <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? S_SHV : S_SHM;
				end
				S_SHV: state_q <= S_SHO;
				S_SHO: begin
					if (fin_q) begin
						if (o_wide > 32'sd8388607) out_q <= 24'sh7FFFFF;
						else if (o_wide < -32'sd8388608) out_q <= 24'sh800000;
						else out_q <= o_wide[23:0];
						state_q <= S_OUT;
					end else begin
						sig_q <= shp;
						stg_q <= stg_q + 1'b1;
						state_q <= S_INIT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || !out_stall)) out_sample <= out_q;
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en)) else $error("memory read and write together");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_INIT) else $error("accepted item not started");

	a_band_rng: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_q < 4'(cbss_pkg::BANDS)) else $error("band index out of range");

	a_stg_rng: assert property (@(posedge clk) disable iff (!arst_n)
		stg_q <= 5'(cbss_pkg::MAX_STAGES)) else $error("stage index out of range");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT) else $error("result without final step");

endmodule
